// ----- src/ssca_pkg.sv -----
// Shared constants, types and helper functions of the slab size-class allocator.
`timescale 1ns / 1ps
package ssca_pkg;

   localparam int ADDR_W      = 32;
   localparam int SIZE_W      = 16;
   localparam int CFG_W       = 20;
   localparam int CLASS_W     = 3;
   localparam int SLOT_W      = 8;
   localparam int OFFSET_W    = 12;
   localparam int CFG_COUNT   = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CFG_SEL_W   = $clog2(CFG_COUNT);

   localparam int PAGE_BYTES     = 4096;
   localparam int MIN_SLOT_BYTES = 16;
   localparam int NUM_CLASSES    = 8;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int MIN_SHIFT  = $clog2(MIN_SLOT_BYTES);
   localparam int SLOTS_MAX  = PAGE_BYTES / MIN_SLOT_BYTES;
   localparam int MAX_SLOT_BYTES = MIN_SLOT_BYTES << (NUM_CLASSES - 1);

   localparam int WORD_BITS       = 32;
   localparam int BIT_W           = $clog2(WORD_BITS);
   localparam int WORDS_PER_CLASS = (SLOTS_MAX > WORD_BITS) ? SLOTS_MAX / WORD_BITS : 1;
   localparam int WORD_W          = (WORDS_PER_CLASS > 1) ? $clog2(WORDS_PER_CLASS) : 1;
   localparam int J_W             = WORD_W + BIT_W;
   localparam int MEM_AW          = CLASS_W + WORD_W;
   localparam int MEM_DEPTH       = 1 << MEM_AW;

   localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef logic [CLASS_W-1:0]   class_type;
   typedef logic [WORD_W-1:0]    word_sel_type;
   typedef logic [J_W-1:0]       slot_num_type;
   typedef logic [WORD_BITS-1:0] bit_word_type;
   typedef logic [CFG_W-1:0]     page_num_type;

   function automatic int slot_count(input int c);
      return SLOTS_MAX >> c;
   endfunction

   function automatic logic class_has_slots(input int c);
      return (c < NUM_CLASSES) && (slot_count(c) != 0);
   endfunction

   function automatic word_sel_type class_last_word(input int c);
      int n;
      n = slot_count(c);
      if (n > WORD_BITS) begin
         return WORD_W'((n >> BIT_W) - 1);
      end
      return '0;
   endfunction

   function automatic bit_word_type class_mask(input int c);
      int n;
      n = slot_count(c);
      if (n >= WORD_BITS) begin
         return '1;
      end
      return WORD_BITS'((64'd1 << n) - 64'd1);
   endfunction

endpackage

// ----- src/ssca_if.sv -----
// Handshake channel interfaces: request, response and register write.
`timescale 1ns / 1ps
interface ssca_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [ssca_pkg::SIZE_W-1:0]   request_size;
   logic [ssca_pkg::ADDR_W-1:0]   free_address;

   modport source (output valid, output opcode, output request_size,
                   output free_address, input ready);
   modport sink   (input valid, input opcode, input request_size,
                   input free_address, output ready);
endinterface

interface ssca_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [ssca_pkg::CLASS_W-1:0]  size_class;
   logic [ssca_pkg::SLOT_W-1:0]   slot_index;
   logic [ssca_pkg::OFFSET_W-1:0] slot_offset;
   logic [ssca_pkg::ADDR_W-1:0]   slot_address;

   modport source (output valid, output ok, output size_class, output slot_index,
                   output slot_offset, output slot_address, input ready);
   modport sink   (input valid, input ok, input size_class, input slot_index,
                   input slot_offset, input slot_address, output ready);
endinterface

interface ssca_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ssca_pkg::CSR_INDEX_W-1:0] index;
   logic [ssca_pkg::CFG_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/slab_size_class_allocator_top.sv -----
// Slab size-class allocator: bitmap memory, request sequencer and response register.
//
// Channels: req_chan takes a request (opcode 0 allocate by request_size, opcode 1
// free by free_address); rsp_chan returns one response per request with ok,
// size_class, slot_index, slot_offset and slot_address. csr_chan writes the page
// frame number of class 0..7 at index 0..7; other indexes are dropped. csr_chan is
// always ready; write it only while no request is in flight.
// Used bits live in a 64 x 32 synchronous RAM, eight words per class. An allocate
// scans one word per cycle from the lowest; a free reads and rewrites one word.
// From accept to response, an allocate passes S_READ, one S_CHECK step per word
// scanned (1 to 8 words) and S_DONE; a free passes S_READ, S_CHECK and S_DONE; a
// rejected size or unknown address passes S_READ and S_DONE. One request is in
// progress at a time; the next waits until the response loads and S_IDLE returns.
// A new request is accepted while the previous response still waits; its result
// is held back until rsp_chan drains. Reset clears the per-word valid flags, so
// every slot reads free at once; no clearing pass is needed.
`timescale 1ns / 1ps
module slab_size_class_allocator_top (
   input  logic      clock,
   input  logic      reset,
   ssca_req_if.sink  req_chan,
   ssca_rsp_if.source rsp_chan,
   ssca_csr_if.sink  csr_chan
);
   import ssca_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic                op_ff, op_in;
   logic                hit_ff, hit_in;
   class_type           class_ff, class_in;
   word_sel_type        word_ff, word_in;
   slot_num_type        slot_ff, slot_in;

   page_num_type        base_ff [CFG_COUNT];

   bit_word_type        used_mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] word_valid_ff;
   bit_word_type        rd_data_ff;
   logic                rd_valid_ff;
   logic                rd_en;
   logic [MEM_AW-1:0]   rd_addr;
   logic                wr_en;
   bit_word_type        wr_data;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff;
   class_type           rsp_class_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic                rsp_load;

   // Request decode
   class_type           alloc_class;
   logic                alloc_hit;
   class_type           free_class;
   logic                free_hit;
   slot_num_type        free_slot;

   // Scan of the word just read
   bit_word_type        cur_word;
   bit_word_type        free_bits;
   logic [BIT_W-1:0]    free_pos;
   logic                found;

   logic [ADDR_W-1:0]   res_offset;
   logic [ADDR_W-1:0]   res_page;

   logic                req_fire;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = rsp_ok_ff;
   assign rsp_chan.size_class   = rsp_class_ff;
   assign rsp_chan.slot_index   = rsp_slot_ff;
   assign rsp_chan.slot_offset  = rsp_offset_ff;
   assign rsp_chan.slot_address = rsp_addr_ff;

   always_comb begin
      alloc_class = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (32'(req_chan.request_size) <= 32'(MIN_SLOT_BYTES << c)) begin
            alloc_class = CLASS_W'(c);
         end
      end
      alloc_hit = (req_chan.request_size != '0) &&
                  (32'(req_chan.request_size) <= 32'(MAX_SLOT_BYTES)) &&
                  class_has_slots(int'(alloc_class));
   end

   always_comb begin
      free_class = '0;
      free_hit   = 1'b0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (class_has_slots(c) && (req_chan.free_address[ADDR_W-1:PAGE_SHIFT] ==
               (ADDR_W-PAGE_SHIFT)'(base_ff[c]))) begin
            free_class = CLASS_W'(c);
            free_hit   = 1'b1;
         end
      end
      free_slot = J_W'((req_chan.free_address & PAGE_MASK) >> (MIN_SHIFT + int'(free_class)));
   end

   always_comb begin
      cur_word  = rd_valid_ff ? rd_data_ff : '0;
      free_bits = ~cur_word & class_mask(int'(class_ff));
      found     = |free_bits;
      free_pos  = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_pos = BIT_W'(i);
         end
      end
   end

   assign res_offset = ADDR_W'(slot_ff) << (MIN_SHIFT + int'(class_ff));
   assign res_page   = ADDR_W'(base_ff[class_ff]) << PAGE_SHIFT;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      hit_in       = hit_ff;
      class_in     = class_ff;
      word_in      = word_ff;
      slot_in      = slot_ff;
      rd_en        = 1'b0;
      rd_addr      = {class_ff, word_ff};
      wr_en        = 1'b0;
      wr_data      = cur_word;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in = req_chan.opcode;
               if (req_chan.opcode == OP_ALLOC) begin
                  hit_in   = alloc_hit;
                  class_in = alloc_class;
                  word_in  = '0;
                  slot_in  = '0;
               end else begin
                  hit_in   = free_hit;
                  class_in = free_class;
                  word_in  = free_slot[J_W-1:BIT_W];
                  slot_in  = free_slot;
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_en    = hit_ff;
            state_in = hit_ff ? S_CHECK : S_DONE;
         end
         S_CHECK: begin
            if (op_ff == OP_FREE) begin
               wr_en    = 1'b1;
               wr_data  = cur_word & ~(bit_word_type'(1) << slot_ff[BIT_W-1:0]);
               state_in = S_DONE;
            end else if (found) begin
               wr_en    = 1'b1;
               wr_data  = cur_word | (bit_word_type'(1) << free_pos);
               slot_in  = {word_ff, free_pos};
               state_in = S_DONE;
            end else if (word_ff == class_last_word(int'(class_ff))) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = {class_ff, word_ff + 1'b1};
               word_in  = word_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         word_valid_ff <= '0;
         hit_ff        <= 1'b0;
         op_ff         <= OP_ALLOC;
         for (int i = 0; i < CFG_COUNT; i++) begin
            base_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         op_ff        <= op_in;
         if (wr_en) begin
            word_valid_ff[{class_ff, word_ff}] <= 1'b1;
         end
         if (csr_chan.valid && (csr_chan.index < CSR_INDEX_W'(CFG_COUNT))) begin
            base_ff[csr_chan.index[CFG_SEL_W-1:0]] <= csr_chan.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
      word_ff  <= word_in;
      slot_ff  <= slot_in;
      if (rd_en) begin
         rd_data_ff  <= used_mem[rd_addr];
         rd_valid_ff <= word_valid_ff[rd_addr];
      end
      if (wr_en) begin
         used_mem[{class_ff, word_ff}] <= wr_data;
      end
      if (rsp_load) begin
         rsp_ok_ff     <= hit_ff;
         rsp_class_ff  <= hit_ff ? class_ff : '0;
         rsp_slot_ff   <= hit_ff ? SLOT_W'(slot_ff) : '0;
         rsp_offset_ff <= hit_ff ? res_offset[OFFSET_W-1:0] : '0;
         rsp_addr_ff   <= hit_ff ? (res_page + res_offset) : '0;
      end
   end

endmodule

// ----- tb/ssca_checker.sv -----
// Checker for the slab allocator: predicts each response from observed traffic and compares.
`timescale 1ns / 1ps
module ssca_checker (
   input  logic clock,
   input  logic reset,
   ssca_req_if  req_mon,
   ssca_rsp_if  rsp_mon,
   ssca_csr_if  csr_mon,
   output int   fail_count,
   output int   pending_count,
   output int   alloc_granted,
   output int   alloc_refused,
   output int   free_hits,
   output int   free_misses
);
   import ssca_pkg::*;

   typedef struct packed {
      logic                ok;
      logic [CLASS_W-1:0]  size_class;
      logic [SLOT_W-1:0]   slot_index;
      logic [OFFSET_W-1:0] slot_offset;
      logic [ADDR_W-1:0]   slot_address;
   } slot_grant_type;

   page_num_type   page_frame [CFG_COUNT];
   logic           slot_used  [NUM_CLASSES][SLOTS_MAX];
   slot_grant_type grants_due [$];
   int             errs;
   int             n_granted;
   int             n_refused;
   int             n_hits;
   int             n_misses;

   function automatic slot_grant_type make_grant(input int c, input int j);
      slot_grant_type    g;
      logic [ADDR_W-1:0] off;
      off            = ADDR_W'(j * (MIN_SLOT_BYTES << c));
      g.ok           = 1'b1;
      g.size_class   = CLASS_W'(c);
      g.slot_index   = SLOT_W'(j);
      g.slot_offset  = off[OFFSET_W-1:0];
      g.slot_address = (ADDR_W'(page_frame[c]) << PAGE_SHIFT) + off;
      return g;
   endfunction

   function automatic slot_grant_type serve_request(input logic op,
                                                    input logic [SIZE_W-1:0] size,
                                                    input logic [ADDR_W-1:0] addr);
      slot_grant_type  g;
      int              c;
      int              j;
      int              span;
      int              nslots;
      logic [ADDR_W:0] start;
      g = '0;
      if (op == OP_ALLOC) begin
         if (size != 0 && size <= MAX_SLOT_BYTES) begin
            c = 0;
            while ((MIN_SLOT_BYTES << c) < size) c++;
            nslots = PAGE_BYTES / (MIN_SLOT_BYTES << c);
            for (j = 0; j < nslots; j++) begin
               if (!slot_used[c][j]) begin
                  slot_used[c][j] = 1'b1;
                  g = make_grant(c, j);
                  break;
               end
            end
         end
         if (g.ok) n_granted++;
         else n_refused++;
      end else begin
         // lowest class wins when pages overlap; range ends do not wrap
         for (c = 0; c < NUM_CLASSES; c++) begin
            span   = MIN_SLOT_BYTES << c;
            nslots = PAGE_BYTES / span;
            start  = {1'b0, ADDR_W'(page_frame[c]) << PAGE_SHIFT};
            if ({1'b0, addr} >= start &&
                {1'b0, addr} < start + (ADDR_W+1)'(nslots * span)) begin
               j = int'(({1'b0, addr} - start) >> (MIN_SHIFT + c));
               slot_used[c][j] = 1'b0;
               g = make_grant(c, j);
               break;
            end
         end
         if (g.ok) n_hits++;
         else n_misses++;
      end
      return g;
   endfunction

   function automatic void check_field(input string name, input logic [ADDR_W-1:0] exp_v,
                                       input logic [ADDR_W-1:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         errs++;
      end
   endfunction

   always @(posedge clock) begin
      slot_grant_type due;
      if (reset) begin
         grants_due.delete();
         foreach (page_frame[i]) page_frame[i] = '0;
         foreach (slot_used[c, j]) slot_used[c][j] = 1'b0;
         errs      = 0;
         n_granted = 0;
         n_refused = 0;
         n_hits    = 0;
         n_misses  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (grants_due.size() == 0) begin
               $error("response with no request outstanding");
               errs++;
            end else begin
               due = grants_due.pop_front();
               check_field("ok", ADDR_W'(due.ok), ADDR_W'(rsp_mon.ok));
               check_field("size_class", ADDR_W'(due.size_class),
                           ADDR_W'(rsp_mon.size_class));
               check_field("slot_index", ADDR_W'(due.slot_index),
                           ADDR_W'(rsp_mon.slot_index));
               check_field("slot_offset", ADDR_W'(due.slot_offset),
                           ADDR_W'(rsp_mon.slot_offset));
               check_field("slot_address", due.slot_address, rsp_mon.slot_address);
            end
         end
         if (csr_mon.valid && csr_mon.ready && csr_mon.index < CFG_COUNT) begin
            page_frame[csr_mon.index[CFG_SEL_W-1:0]] = csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready) begin
            grants_due.push_back(serve_request(req_mon.opcode, req_mon.request_size,
                                               req_mon.free_address));
         end
      end
      fail_count    <= errs;
      pending_count <= grants_due.size();
      alloc_granted <= n_granted;
      alloc_refused <= n_refused;
      free_hits     <= n_hits;
      free_misses   <= n_misses;
   end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the slab allocator: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps
module tb;
   import ssca_pkg::*;

   localparam int TAIL_CYCLES  = 12;
   localparam int QUIET_LIMIT  = 4000;

   logic clock;
   logic reset;

   ssca_req_if req_chan ();
   ssca_rsp_if rsp_chan ();
   ssca_csr_if csr_chan ();

   int fail_count;
   int pending_count;
   int alloc_granted;
   int alloc_refused;
   int free_hits;
   int free_misses;

   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int           quiet_cycles;
   page_num_type frame_plan [CFG_COUNT];

   slab_size_class_allocator_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   ssca_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .alloc_granted (alloc_granted),
      .alloc_refused (alloc_refused),
      .free_hits     (free_hits),
      .free_misses   (free_misses)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_page_frames();
      int i;
      for (i = 0; i <= CFG_COUNT; i++) begin
         csr_chan.valid <= 1'b1;
         if (i < CFG_COUNT) begin
            csr_chan.index <= CSR_INDEX_W'(i);
            csr_chan.data  <= frame_plan[i];
         end else begin
            // unmapped index, must leave every page untouched
            csr_chan.index <= CSR_INDEX_W'($urandom_range(15, CFG_COUNT));
            csr_chan.data  <= page_num_type'($urandom);
         end
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
   endtask

   task automatic push_request(input logic op, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.opcode       <= op;
      req_chan.request_size <= size;
      req_chan.free_address <= addr;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic settle_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic random_request(input int alloc_pct);
      int                c;
      int                j;
      int                span;
      int                nslots;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      size = SIZE_W'($urandom);
      addr = $urandom;
      if ($urandom_range(99) < alloc_pct) begin
         if ($urandom_range(99) < 6) begin
            if ($urandom_range(1) == 0) size = '0;
            else size = SIZE_W'($urandom_range(65535, MAX_SLOT_BYTES + 1));
         end else begin
            // class 0 favored so its bitmap fills deep
            c    = ($urandom_range(9) < 4) ? 0 : $urandom_range(NUM_CLASSES - 1);
            span = MIN_SLOT_BYTES << c;
            size = SIZE_W'($urandom_range(span, (c == 0) ? 1 : span / 2 + 1));
         end
         push_request(OP_ALLOC, size, addr);
      end else begin
         if ($urandom_range(99) >= 10) begin
            c      = $urandom_range(NUM_CLASSES - 1);
            span   = MIN_SLOT_BYTES << c;
            nslots = PAGE_BYTES / span;
            j      = ($urandom_range(1) == 0) ? $urandom_range(nslots - 1)
                                              : $urandom_range((nslots - 1) / 4);
            addr   = (ADDR_W'(frame_plan[c]) << PAGE_SHIFT) + ADDR_W'(j * span) +
                     ADDR_W'($urandom_range(span - 1));
         end
         push_request(OP_FREE, size, addr);
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                            input int alloc_pct);
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
      repeat (count) begin
         random_request(alloc_pct);
         if ($urandom_range(39) == 0) settle_idle();
      end
      settle_idle();
   endtask

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.opcode       = OP_ALLOC;
      req_chan.request_size = '0;
      req_chan.free_address = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = '0;
      csr_chan.data         = '0;
      rsp_chan.ready        = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (frame_plan[i]) frame_plan[i] = page_num_type'($urandom);
      frame_plan[0]               = '0;
      frame_plan[NUM_CLASSES - 1] = '1;
      write_page_frames();

      push_request(OP_ALLOC, 16'd0, $urandom);
      push_request(OP_ALLOC, 16'd2049, $urandom);
      push_request(OP_ALLOC, 16'hFFFF, $urandom);
      push_request(OP_ALLOC, 16'd1, $urandom);
      push_request(OP_ALLOC, 16'd16, $urandom);
      push_request(OP_ALLOC, 16'd17, $urandom);
      push_request(OP_ALLOC, 16'd2048, $urandom);
      push_request(OP_ALLOC, 16'd1025, $urandom);
      push_request(OP_ALLOC, 16'd2047, $urandom);                // largest class exhausted
      push_request(OP_FREE, SIZE_W'($urandom), 32'hFFFF_FFFF);   // last byte below 2^32
      push_request(OP_ALLOC, 16'd1500, $urandom);
      push_request(OP_FREE, SIZE_W'($urandom), 32'h0000_0000);
      push_request(OP_FREE, SIZE_W'($urandom), 32'h0000_0005);   // slot already free
      push_request(OP_FREE, SIZE_W'($urandom), 32'h0000_1000);
      push_request(OP_ALLOC, 16'd8, $urandom);
      run_phase(0, 0, 170, 60);

      // every page at frame zero: all overlap, class 0 takes every free that hits
      foreach (frame_plan[i]) frame_plan[i] = '0;
      write_page_frames();
      push_request(OP_FREE, SIZE_W'($urandom), 32'h0000_0FFF);
      push_request(OP_FREE, SIZE_W'($urandom), 32'h0000_1000);
      run_phase(59, 0, 170, 55);

      foreach (frame_plan[i]) frame_plan[i] = '1;
      write_page_frames();
      push_request(OP_FREE, SIZE_W'($urandom), 32'hFFFF_FFFF);
      push_request(OP_FREE, SIZE_W'($urandom), 32'hFFFF_EFFF);
      run_phase(0, 59, 170, 65);

      foreach (frame_plan[i]) frame_plan[i] = page_num_type'($urandom);
      write_page_frames();
      run_phase(7, 7, 200, 70);

      $display("covered %0d allocations granted, %0d refused, %0d frees hit, %0d missed",
               alloc_granted, alloc_refused, free_hits, free_misses);
      $display("over four page layouts and four idle and stall mixes");
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/ssca_pkg.sv
src/ssca_if.sv
src/slab_size_class_allocator_top.sv
tb/ssca_checker.sv
tb/tb.sv
